// ===== rtl/wbsc_pkg.sv =====
// shared types and constants of the beacon security classifier
`default_nettype none

package wbsc_pkg;

    // parse stage of the current information element
    typedef enum logic [1:0] {
        STAGE_WAIT = 2'd0,
        STAGE_TAG  = 2'd1,
        STAGE_BODY = 2'd2
    } stage_t;

    // security class codes
    localparam logic [2:0] CLASS_OPEN = 3'd0;
    localparam logic [2:0] CLASS_WEP  = 3'd1;
    localparam logic [2:0] CLASS_WPA  = 3'd2;
    localparam logic [2:0] CLASS_WPA2 = 3'd3;
    localparam logic [2:0] CLASS_WPA3 = 3'd4;

    // element flag bits
    localparam logic [2:0] FLAG_RSN = 3'b001;
    localparam logic [2:0] FLAG_WPA = 3'b010;
    localparam logic [2:0] FLAG_SAE = 3'b100;

    // frame layout and element constants
    localparam logic [7:0] TAG_RSN        = 8'h30;
    localparam logic [7:0] TAG_VENDOR     = 8'hdd;
    localparam logic [7:0] TYPE_BEACON    = 8'h80;
    localparam logic [7:0] TYPE_PROBE_RSP = 8'h50;
    localparam logic [7:0] PRIVACY_MASK   = 8'h10;
    localparam logic [7:0] AKM_SAE        = 8'd8;
    localparam logic [7:0] SSID_SHOWN_MAX = 8'd32;
    localparam int unsigned POS_PRIVACY   = 34;
    localparam int unsigned POS_SSID_LEN  = 37;
    localparam int unsigned POS_ELEMENTS  = 38;

    // one input item
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_mgmt;
        logic       last_byte;
    } item_t;

    // one result item
    typedef struct packed {
        logic       frame_ok;
        logic [2:0] auth_class;
    } res_t;

    // bytes of the vendor WPA header 00:50:F2:01
    function automatic logic [7:0] wpa_oui_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h00;
            2'd1:    val = 8'h50;
            2'd2:    val = 8'hF2;
            default: val = 8'h01;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wbsc_frame_parser.sv =====
// per-frame parse state and classification of one byte item
`default_nettype none

module wbsc_frame_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire wbsc_pkg::item_t item,
    output wbsc_pkg::res_t      result
);

    localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned EW = $clog2(MAX_FRAME_BYTES + 300);

    typedef struct packed {
        logic [PW-1:0]    pos;
        logic [7:0]       type_byte;
        logic             privacy;
        logic [7:0]       ssid_len;
        logic [EW-1:0]    nes;
        logic [7:0]       tag;
        logic [7:0]       len;
        wbsc_pkg::stage_t stage;
        logic [15:0]      suites;
        logic [2:0]       pending;
        logic [2:0]       seen;
    } st_t;

    st_t st_reg;
    st_t st_upd;
    st_t st_next;

    logic          at_max;
    logic [EW-1:0] p_ext;
    logic [EW-1:0] p_inc;
    logic [EW-1:0] end_a;
    logic [EW-1:0] end_b;
    logic [EW-1:0] off_wide;
    logic [7:0]    off;
    logic [7:0]    q17;
    logic [7:0]    b;
    logic [7:0]    shown;

    assign b      = item.frame_byte;
    assign at_max = (st_reg.pos == PW'(MAX_FRAME_BYTES));
    assign p_ext  = EW'(st_reg.pos);
    assign p_inc  = p_ext + EW'(1);

    // state after taking one byte
    always_comb
    begin
        st_upd   = st_reg;
        end_a    = st_reg.nes + EW'(st_reg.len) + EW'(2);
        end_b    = '0;
        off_wide = '0;
        off      = '0;
        q17      = '0;
        if (!at_max)
        begin
            // close an element already complete before this byte
            if (st_reg.stage == wbsc_pkg::STAGE_BODY && p_ext >= end_a &&
                p_inc >= st_reg.nes + EW'(3))
            begin
                st_upd.seen    = st_reg.seen | st_reg.pending;
                st_upd.pending = '0;
                st_upd.nes     = end_a;
                st_upd.stage   = wbsc_pkg::STAGE_WAIT;
            end
            // fixed header fields
            if (st_reg.pos == PW'(0))
                st_upd.type_byte = b;
            if (st_reg.pos == PW'(wbsc_pkg::POS_PRIVACY))
                st_upd.privacy = |(b & wbsc_pkg::PRIVACY_MASK);
            if (st_reg.pos == PW'(wbsc_pkg::POS_SSID_LEN))
            begin
                st_upd.ssid_len = b;
                st_upd.nes      = EW'(wbsc_pkg::POS_ELEMENTS) + EW'(b);
                st_upd.stage    = wbsc_pkg::STAGE_WAIT;
            end
            // element walk
            if (st_reg.pos >= PW'(wbsc_pkg::POS_ELEMENTS))
            begin
                case (st_upd.stage)
                    wbsc_pkg::STAGE_WAIT:
                    begin
                        if (p_ext == st_upd.nes)
                        begin
                            st_upd.tag   = b;
                            st_upd.stage = wbsc_pkg::STAGE_TAG;
                        end
                    end
                    wbsc_pkg::STAGE_TAG:
                    begin
                        st_upd.len     = b;
                        st_upd.stage   = wbsc_pkg::STAGE_BODY;
                        st_upd.suites  = '0;
                        st_upd.pending = (st_upd.tag == wbsc_pkg::TAG_RSN) ?
                                         wbsc_pkg::FLAG_RSN : 3'b000;
                    end
                    default:
                    begin
                        off_wide = p_ext - st_upd.nes - EW'(2);
                        off      = off_wide[7:0];
                        q17      = off - 8'd17;
                        if (off_wide < EW'(st_upd.len))
                        begin
                            if (st_upd.tag == wbsc_pkg::TAG_RSN)
                            begin
                                if (off == 8'd12)
                                    st_upd.suites[7:0] = b;
                                else if (off == 8'd13)
                                    st_upd.suites[15:8] = b;
                                else if (st_upd.len >= 8'd14 && off >= 8'd17 &&
                                         q17[1:0] == 2'd0 &&
                                         {10'd0, q17[7:2]} < st_upd.suites &&
                                         b == wbsc_pkg::AKM_SAE)
                                    st_upd.pending = st_upd.pending | wbsc_pkg::FLAG_SAE;
                            end
                            else if (st_upd.tag == wbsc_pkg::TAG_VENDOR &&
                                     st_upd.len >= 8'd4 && off < 8'd4)
                            begin
                                if (off == 8'd0)
                                begin
                                    if (b == wbsc_pkg::wpa_oui_byte(2'd0))
                                        st_upd.pending = st_upd.pending | wbsc_pkg::FLAG_WPA;
                                end
                                else if (b != wbsc_pkg::wpa_oui_byte(off[1:0]))
                                begin
                                    st_upd.pending = st_upd.pending & ~wbsc_pkg::FLAG_WPA;
                                end
                            end
                        end
                    end
                endcase
            end
            // close an element that this byte completes
            end_b = st_upd.nes + EW'(st_upd.len) + EW'(2);
            if (st_upd.stage == wbsc_pkg::STAGE_BODY && p_inc >= end_b &&
                p_inc >= st_upd.nes + EW'(3))
            begin
                st_upd.seen    = st_upd.seen | st_upd.pending;
                st_upd.pending = '0;
                st_upd.nes     = end_b;
                st_upd.stage   = wbsc_pkg::STAGE_WAIT;
            end
            st_upd.pos = st_reg.pos + PW'(1);
        end
    end

    // classification from the updated state
    always_comb
    begin
        shown = (st_upd.ssid_len > wbsc_pkg::SSID_SHOWN_MAX) ?
                wbsc_pkg::SSID_SHOWN_MAX : st_upd.ssid_len;
        if (!st_upd.privacy)
            result.auth_class = wbsc_pkg::CLASS_OPEN;
        else if (st_upd.pos < PW'(wbsc_pkg::POS_ELEMENTS))
            result.auth_class = wbsc_pkg::CLASS_WEP;
        else if (|(st_upd.seen & wbsc_pkg::FLAG_SAE))
            result.auth_class = wbsc_pkg::CLASS_WPA3;
        else if (|(st_upd.seen & wbsc_pkg::FLAG_RSN))
            result.auth_class = wbsc_pkg::CLASS_WPA2;
        else if (|(st_upd.seen & wbsc_pkg::FLAG_WPA))
            result.auth_class = wbsc_pkg::CLASS_WPA;
        else
            result.auth_class = wbsc_pkg::CLASS_WEP;
        result.frame_ok = item.is_mgmt &&
                          st_upd.pos >= PW'(wbsc_pkg::POS_ELEMENTS) &&
                          (st_upd.type_byte == wbsc_pkg::TYPE_BEACON ||
                           st_upd.type_byte == wbsc_pkg::TYPE_PROBE_RSP) &&
                          EW'(wbsc_pkg::POS_ELEMENTS) + EW'(shown) <= EW'(st_upd.pos);
    end

    // frame state clears after the last byte
    always_comb
    begin
        if (!step)
            st_next = st_reg;
        else if (item.last_byte)
            st_next = '0;
        else
            st_next = st_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pos <= PW'(MAX_FRAME_BYTES))
        else $error("byte count beyond frame limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> st_reg.pos == '0 && st_reg.seen == '0)
        else $error("frame state not cleared after last byte");

    a_no_element_before_ies: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pos <= PW'(wbsc_pkg::POS_ELEMENTS) |->
        st_reg.stage == wbsc_pkg::STAGE_WAIT)
        else $error("element parse started inside fixed header");
`endif

endmodule

`default_nettype wire

// ===== rtl/wifi_beacon_security_classifier.sv =====
// top level of the beacon security classifier: input stage, parser, result register
`default_nettype none

// Takes a received 802.11 frame one byte per item and, on the item marked
// tlast, delivers one result item with the security class (open, WEP, WPA,
// WPA2, WPA3) and a flag for an acceptable beacon or probe response. Bytes
// are taken at one per cycle while the stream is not stopped; each byte
// passes an input register, then a single pass of counter and compare
// logic that updates the frame state, and the class lands in the result
// register as its last byte leaves the input register. Only a last byte
// waits: it is held in the input register while an earlier result is not
// yet taken, which stops the stream. Bytes past MAX_FRAME_BYTES are
// dropped and the frame is judged by its first MAX_FRAME_BYTES bytes.
module wifi_beacon_security_classifier #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] frame_byte
    input  wire logic       s_tuser,   // [0] is_mgmt
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [2:0] auth_class, [3] frame_ok, [7:4] zero
);

    logic            in_valid_reg;
    logic            in_valid_next;
    wbsc_pkg::item_t in_item_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    wbsc_pkg::res_t  out_res_reg;
    wbsc_pkg::res_t  parse_res;
    logic            proc;
    logic            take;

    // a held byte moves on unless it is a last byte behind a waiting result
    assign proc     = in_valid_reg &&
                      (!in_item_reg.last_byte || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign take     = s_tvalid && s_tready;

    // input stage
    always_comb
    begin
        if (take)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.frame_byte <= s_tdata;
            in_item_reg.is_mgmt    <= s_tuser;
            in_item_reg.last_byte  <= s_tlast;
        end
    end

    wbsc_frame_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc),
        .item  (in_item_reg),
        .result(parse_res)
    );

    // result register
    always_comb
    begin
        if (proc && in_item_reg.last_byte)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_item_reg.last_byte)
            out_res_reg <= parse_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.frame_ok, out_res_reg.auth_class};

`ifndef ASSERT_OFF
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= wbsc_pkg::CLASS_WPA3)
        else $error("security class out of range");

    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc |-> !s_tready)
        else $error("input stage overwritten while held");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(proc && in_item_reg.last_byte))
        else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
